// ===== src/b64le_pkg.sv =====
`default_nettype none

package b64le_pkg;

    localparam int MaxChars = 5;
    localparam int CountWidth = $clog2(MaxChars + 1);

    localparam logic [7:0] CharPad = 8'h3d;
    localparam logic [7:0] CharNewline = 8'h0a;
    localparam logic [7:0] CharPlus = 8'h2b;
    localparam logic [7:0] CharSlash = 8'h2f;
    localparam logic [5:0] GroupsPerLineReset = 6'd18;

    typedef logic [MaxChars-1:0][7:0] char_vec_t;

    typedef struct packed {
        char_vec_t             chars;
        logic [CountWidth-1:0] count;
        logic                  eom;
    } burst_t;

    typedef struct packed {
        logic [15:0] pending_bits;
        logic [1:0]  pending_count;
        logic [5:0]  groups_on_line;
    } enc_state_t;

    function automatic logic [7:0] sym_char(input logic [5:0] v);
        logic [7:0] c;
        if (v < 6'd26) begin
            c = 8'h41 + {2'b00, v};
        end else if (v < 6'd52) begin
            c = 8'h61 + {2'b00, v} - 8'd26;
        end else if (v < 6'd62) begin
            c = 8'h30 + {2'b00, v} - 8'd52;
        end else if (v == 6'd62) begin
            c = CharPlus;
        end else begin
            c = CharSlash;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== src/b64le_encode.sv =====
`default_nettype none

module b64le_encode (
    input  var b64le_pkg::enc_state_t state,
    input  wire logic [5:0]           groups_per_line,
    input  wire logic [7:0]           data_byte,
    input  wire logic                 final_byte,
    output var b64le_pkg::enc_state_t state_next,
    output var b64le_pkg::burst_t     burst
);
    import b64le_pkg::*;

    logic [23:0] full_v;
    logic [5:0]  groups_inc;
    logic        line_full;
    logic        line_busy;
    logic [7:0]  held;

    always_comb
    begin
        full_v = {state.pending_bits, data_byte};
        groups_inc = state.groups_on_line + 6'd1;
        line_full = (groups_inc == groups_per_line);
        line_busy = (state.groups_on_line != 6'd0);
        held = state.pending_bits[7:0];

        burst.chars = '0;
        burst.count = '0;
        burst.eom = final_byte;
        state_next = '0;

        if (state.pending_count[1])
        begin
            burst.chars[0] = sym_char(full_v[23:18]);
            burst.chars[1] = sym_char(full_v[17:12]);
            burst.chars[2] = sym_char(full_v[11:6]);
            burst.chars[3] = sym_char(full_v[5:0]);
            burst.chars[4] = CharNewline;
            burst.count = line_full ? CountWidth'(5) : CountWidth'(4);
            state_next.groups_on_line = (line_full || final_byte) ? 6'd0 : groups_inc;
        end
        else if (final_byte)
        begin
            if (state.pending_count == 2'd0)
            begin
                burst.chars[0] = sym_char(data_byte[7:2]);
                burst.chars[1] = sym_char({data_byte[1:0], 4'b0000});
                burst.chars[2] = CharPad;
            end
            else
            begin
                burst.chars[0] = sym_char(held[7:2]);
                burst.chars[1] = sym_char({held[1:0], data_byte[7:4]});
                burst.chars[2] = sym_char({data_byte[3:0], 2'b00});
            end
            burst.chars[3] = CharPad;
            burst.chars[4] = CharNewline;
            burst.count = line_busy ? CountWidth'(5) : CountWidth'(4);
        end
        else
        begin
            state_next.pending_bits = {held, data_byte};
            state_next.pending_count = state.pending_count + 2'd1;
            state_next.groups_on_line = state.groups_on_line;
        end
    end

endmodule

`default_nettype wire

// ===== src/b64le_serializer.sv =====
`default_nettype none

module b64le_serializer (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             load,
    input  var b64le_pkg::burst_t burst,
    input  wire logic             out_stall,
    output wire logic             free,
    output wire logic             out_valid,
    output wire logic [7:0]       out_char,
    output wire logic             end_of_message
);
    import b64le_pkg::*;

    char_vec_t             chars_reg;
    char_vec_t             chars_next;
    logic [CountWidth-1:0] count_reg;
    logic [CountWidth-1:0] count_next;
    logic                  eom_reg;
    logic                  eom_next;
    logic                  take;

    assign out_valid = (count_reg != '0);
    assign take = out_valid && !out_stall;
    assign free = (count_reg == '0) || (take && (count_reg == CountWidth'(1)));
    assign out_char = chars_reg[0];
    assign end_of_message = eom_reg && (count_reg == CountWidth'(1));

    always_comb
    begin
        chars_next = chars_reg;
        count_next = count_reg;
        eom_next = eom_reg;
        if (load)
        begin
            chars_next = burst.chars;
            count_next = burst.count;
            eom_next = burst.eom;
        end
        else if (take)
        begin
            chars_next = chars_reg >> 8;
            count_next = count_reg - CountWidth'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            eom_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            eom_reg <= eom_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chars_reg <= chars_next;
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CountWidth'(MaxChars))
        else $error("Character count exceeds the burst size.");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> free)
        else $error("Word loaded over characters not yet delivered.");

endmodule

`default_nettype wire

// ===== src/base64_line_wrapped_encoder_core.sv =====
`default_nettype none

// Streaming base64 encoder with line wrapping. One byte is taken per word; a byte that
// completes no group is taken without stall even while earlier characters drain. A byte
// that completes a group, or closes the message, yields four or five characters, which
// leave one per cycle through the output register while out_stall is low. The next
// character-producing byte is taken in the cycle the last queued character leaves.
// The line length in groups is written through cfg_write_en and groups_per_line; the user
// must write it only while the block is idle (not enforced here). It resets to 18 groups.
module base64_line_wrapped_encoder_core (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_write_en,
    input  wire logic [5:0] groups_per_line,
    input  wire logic       in_valid,
    output wire logic       in_stall,
    input  wire logic [7:0] data_byte,
    input  wire logic       final_byte,
    output wire logic       out_valid,
    input  wire logic       out_stall,
    output wire logic [7:0] out_char,
    output wire logic       end_of_message
);
    import b64le_pkg::*;

    enc_state_t state_reg;
    enc_state_t state_next;
    logic [5:0] gpl_reg;
    burst_t     burst;
    logic       produces;
    logic       free;
    logic       accept;
    logic       load;

    b64le_encode u_encode (
        .state           (state_reg),
        .groups_per_line (gpl_reg),
        .data_byte       (data_byte),
        .final_byte      (final_byte),
        .state_next      (state_next),
        .burst           (burst)
    );

    assign produces = (burst.count != '0);
    assign in_stall = produces && !free;
    assign accept = in_valid && !in_stall;
    assign load = accept && produces;

    b64le_serializer u_serializer (
        .clk            (clk),
        .rst_n          (rst_n),
        .load           (load),
        .burst          (burst),
        .out_stall      (out_stall),
        .free           (free),
        .out_valid      (out_valid),
        .out_char       (out_char),
        .end_of_message (end_of_message)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
            gpl_reg <= GroupsPerLineReset;
        end
        else
        begin
            if (accept)
            begin
                state_reg <= state_next;
            end
            if (cfg_write_en)
            begin
                gpl_reg <= groups_per_line;
            end
        end
    end

    a_count_below_three: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.pending_count != 2'd3)
        else $error("Held byte count reached three.");

    a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && final_byte) |=> (state_reg == '0))
        else $error("Encoder state not cleared after the final byte.");

endmodule

`default_nettype wire
